### rtl/lcd_pkg.sv
// Shared constants and types for the lidar capsule decoder.
`timescale 1ns / 1ps
package lcd_pkg;

    localparam int CAPSULE_BYTES   = 84;
    localparam int CABIN_COUNT     = 16;
    localparam int CABIN_BYTES     = 5;
    localparam int CABIN_BASE      = 4;
    localparam int FULL_CIRCLE_Q6  = 360 << 6;
    localparam int RAM_AW          = 8;
    localparam int RAM_DEPTH       = 1 << RAM_AW;

    localparam logic [1:0] ST_POINT = 2'd0;
    localparam logic [1:0] ST_CSUM  = 2'd1;
    localparam logic [1:0] ST_NOPTS = 2'd2;

    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_QUALITY     = 2'd2;

    typedef struct packed {
        logic [3:0] sync_first;
        logic [3:0] sync_second;
        logic [7:0] quality;
    } cfg_t;

    typedef struct packed {
        logic       take_byte;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       cap_en;
        logic [2:0] cap_sel;
        logic [3:0] cabin;
        logic       load_point;
        logic       half;
        logic       last_pt;
        logic       load_status;
        logic [1:0] status_code;
    } cmd_t;

    typedef struct packed {
        logic cap_end;
        logic csum_bad;
        logic decode;
    } evt_t;

endpackage

### rtl/lcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lcd_datapath.sv
// Capsule framing, double-buffered capsule store and point computation.
`timescale 1ns / 1ps
module lcd_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  lcd_pkg::cfg_t      cfg,
    input  lcd_pkg::cmd_t      cmd,
    output lcd_pkg::evt_t      evt,
    input  logic [7:0]         in_byte,
    input  logic               in_restart,
    output logic [1:0]         out_status,
    output logic [14:0]        out_angle,
    output logic [15:0]        out_distance,
    output logic [7:0]         out_quality,
    output logic [15:0]        out_revs,
    output logic               out_last
);
    import lcd_pkg::*;

    localparam logic [15:0] FULL16 = 16'(FULL_CIRCLE_Q6);

    logic [6:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] cur_reg, cur_next;
    logic [14:0] prev_reg, prev_next;
    logic        pv_reg, pv_next;
    logic        bank_reg, bank_next;
    logic [15:0] wrap_reg, wrap_next;
    logic [10:0] inc_reg, inc_next;
    logic [14:0] raw_reg, raw_next;
    logic [7:0]  cab_reg [CABIN_BYTES];
    logic [1:0]  st_reg, st_next;
    logic [14:0] ang_reg, ang_next;
    logic [15:0] dist_reg, dist_next;
    logic [7:0]  qual_reg, qual_next;
    logic        last_reg, last_next;

    logic [6:0]  pos_eff;
    logic [7:0]  xor_eff, xor_new;
    logic        sync_fail;
    logic [15:0] diff, diff_w;
    logic        wrap_hit;
    logic [14:0] raw_init;
    logic        ram_we;
    logic [RAM_AW-1:0] waddr, raddr;
    logic [6:0]  roff;
    logic [7:0]  rdata;
    logic [15:0] word;
    logic [5:0]  off6;
    logic [16:0] off_ext, a_raw;
    logic [14:0] a_fix;
    logic [15:0] raw_sum;
    logic [15:0] dist_w;

    assign pos_eff   = in_restart ? 7'd0 : pos_reg;
    assign xor_eff   = in_restart ? 8'd0 : xor_reg;
    assign sync_fail = (pos_eff == 7'd0 && in_byte[7:4] != cfg.sync_first) ||
                       (pos_eff == 7'd1 && in_byte[7:4] != cfg.sync_second);
    assign xor_new   = (pos_eff >= 7'd2) ? (xor_eff ^ in_byte) : xor_eff;

    assign evt.cap_end  = !sync_fail && pos_eff == 7'(CAPSULE_BYTES - 1);
    assign evt.csum_bad = sum_reg != xor_new;
    assign evt.decode   = pv_reg && !cur_reg[15];

    assign wrap_hit = prev_reg > cur_reg[14:0];
    assign diff     = {1'b0, cur_reg[14:0]} - {1'b0, prev_reg};
    assign diff_w   = wrap_hit ? diff + FULL16 : diff;
    assign raw_init = ({1'b0, prev_reg} >= FULL16) ? 15'({1'b0, prev_reg} - FULL16)
                                                   : prev_reg;

    assign ram_we = cmd.take_byte && !sync_fail;
    assign waddr  = {bank_reg, pos_eff};
    assign roff   = 7'(CABIN_BASE) + {1'b0, cmd.cabin, 2'b00} + {3'b000, cmd.cabin}
                  + {4'b0000, cmd.rd_sel};
    assign raddr  = {bank_reg, roff};

    lcd_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (in_byte),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign word    = cmd.half ? {cab_reg[3], cab_reg[2]} : {cab_reg[1], cab_reg[0]};
    assign off6    = cmd.half ? {cab_reg[2][1:0], cab_reg[4][7:4]}
                              : {cab_reg[0][1:0], cab_reg[4][3:0]};
    assign off_ext = {{8{off6[5]}}, off6, 3'b000};
    assign a_raw   = {2'b00, raw_reg} - off_ext;
    assign a_fix   = a_raw[16] ? 15'(a_raw + 17'(FULL_CIRCLE_Q6))
                   : (a_raw >= 17'(FULL_CIRCLE_Q6)) ? 15'(a_raw - 17'(FULL_CIRCLE_Q6))
                   : a_raw[14:0];
    assign raw_sum = {1'b0, raw_reg} + {5'b00000, inc_reg};
    assign dist_w  = {word[15:2], 2'b00};

    always_comb begin
        pos_next  = pos_reg;
        xor_next  = xor_reg;
        sum_next  = sum_reg;
        cur_next  = cur_reg;
        prev_next = prev_reg;
        pv_next   = pv_reg;
        bank_next = bank_reg;
        wrap_next = wrap_reg;
        inc_next  = inc_reg;
        raw_next  = raw_reg;
        st_next   = st_reg;
        ang_next  = ang_reg;
        dist_next = dist_reg;
        qual_next = qual_reg;
        last_next = last_reg;
        if (cmd.take_byte) begin
            if (sync_fail) begin
                pos_next = '0;
                xor_next = '0;
                pv_next  = 1'b0;
            end else begin
                case (pos_eff)
                    7'd0:    sum_next[3:0]  = in_byte[3:0];
                    7'd1:    sum_next[7:4]  = in_byte[3:0];
                    7'd2:    cur_next[7:0]  = in_byte;
                    7'd3:    cur_next[15:8] = in_byte;
                    default: ;
                endcase
                if (evt.cap_end) begin
                    pos_next = '0;
                    xor_next = '0;
                    if (evt.csum_bad) begin
                        pv_next = 1'b0;
                    end else begin
                        pv_next   = 1'b1;
                        prev_next = cur_reg[14:0];
                        bank_next = !bank_reg;
                        if (evt.decode) begin
                            inc_next  = diff_w[15:5];
                            raw_next  = raw_init;
                            wrap_next = wrap_reg + {15'd0, wrap_hit};
                        end
                    end
                end else begin
                    pos_next = pos_eff + 7'd1;
                    xor_next = xor_new;
                end
            end
        end
        if (cmd.load_status) begin
            st_next   = cmd.status_code;
            ang_next  = '0;
            dist_next = '0;
            qual_next = '0;
            last_next = 1'b1;
        end
        if (cmd.load_point) begin
            st_next   = ST_POINT;
            ang_next  = a_fix;
            dist_next = dist_w;
            qual_next = (dist_w != 16'd0) ? cfg.quality : 8'd0;
            last_next = cmd.last_pt;
            raw_next  = (raw_sum >= FULL16) ? 15'(raw_sum - FULL16) : raw_sum[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            xor_reg  <= '0;
            pv_reg   <= 1'b0;
            bank_reg <= 1'b0;
            wrap_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            xor_reg  <= xor_next;
            pv_reg   <= pv_next;
            bank_reg <= bank_next;
            wrap_reg <= wrap_next;
        end
        sum_reg  <= sum_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        inc_reg  <= inc_next;
        raw_reg  <= raw_next;
        st_reg   <= st_next;
        ang_reg  <= ang_next;
        dist_reg <= dist_next;
        qual_reg <= qual_next;
        last_reg <= last_next;
        if (cmd.cap_en) begin
            cab_reg[cmd.cap_sel] <= rdata;
        end
    end

    assign out_status   = st_reg;
    assign out_angle    = ang_reg;
    assign out_distance = dist_reg;
    assign out_quality  = qual_reg;
    assign out_revs     = wrap_reg;
    assign out_last     = last_reg;

endmodule

### rtl/lcd_ctrl.sv
// Controller state machine: byte intake, cabin reads and result transfers.
`timescale 1ns / 1ps
module lcd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  lcd_pkg::evt_t evt,
    output lcd_pkg::cmd_t cmd
);
    import lcd_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_LOAD, S_SEND, S_STATUS} state_t;

    state_t     state_reg;
    logic [3:0] cabin_reg;
    logic [2:0] k_reg;
    logic       half_reg;
    logic       valid_reg;
    logic       go_decode;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = valid_reg;
    assign go_decode = evt.cap_end && !evt.csum_bad && evt.decode;

    always_comb begin
        cmd.take_byte   = in_ready && in_valid;
        cmd.rd_en       = state_reg == S_READ && k_reg < 3'(CABIN_BYTES);
        cmd.rd_sel      = k_reg;
        cmd.cap_en      = state_reg == S_READ && k_reg != 3'd0;
        cmd.cap_sel     = k_reg - 3'd1;
        cmd.cabin       = cabin_reg;
        cmd.load_point  = state_reg == S_LOAD;
        cmd.half        = half_reg;
        cmd.last_pt     = half_reg && cabin_reg == 4'(CABIN_COUNT - 1);
        cmd.load_status = cmd.take_byte && evt.cap_end && !go_decode;
        cmd.status_code = evt.csum_bad ? ST_CSUM : ST_NOPTS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cabin_reg <= '0;
            k_reg     <= '0;
            half_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (cmd.take_byte && go_decode) begin
                        state_reg <= S_READ;
                        cabin_reg <= '0;
                        k_reg     <= '0;
                    end else if (cmd.load_status) begin
                        state_reg <= S_STATUS;
                        valid_reg <= 1'b1;
                    end
                end
                S_READ: begin
                    if (k_reg == 3'(CABIN_BYTES)) begin
                        state_reg <= S_LOAD;
                        half_reg  <= 1'b0;
                    end else begin
                        k_reg <= k_reg + 3'd1;
                    end
                end
                S_LOAD: begin
                    state_reg <= S_SEND;
                    valid_reg <= 1'b1;
                end
                S_SEND: begin
                    if (out_ready) begin
                        valid_reg <= 1'b0;
                        if (!half_reg) begin
                            half_reg  <= 1'b1;
                            state_reg <= S_LOAD;
                        end else if (cabin_reg == 4'(CABIN_COUNT - 1)) begin
                            state_reg <= S_IDLE;
                        end else begin
                            cabin_reg <= cabin_reg + 4'd1;
                            k_reg     <= '0;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_STATUS: begin
                    if (out_ready) begin
                        valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/lidar_capsule_decoder.sv
// Top level of the lidar express-scan capsule decoder with its register port.
// A status result is valid the cycle after the byte that closes its capsule.
// The closing byte of a valid capsule starts decode of the cached capsule:
// 16 cabins, each read from the RAM (5 bytes) and then sent as 2 points;
// no byte is taken until that decode is done.
// Synchronous active-low reset clears framing, cache valid and wrap count.
`timescale 1ns / 1ps
module lidar_capsule_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic [0:0]  s_tuser,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // angle, distance, quality, revolution_count
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcd_pkg::*;

    cfg_t        cfg_reg;
    cmd_t        cmd;
    evt_t        evt;
    logic [14:0] angle;
    logic [15:0] distance;
    logic [7:0]  quality;
    logic [15:0] revs;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first  <= 4'd10;
            cfg_reg.sync_second <= 4'd5;
            cfg_reg.quality     <= 8'd188;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_SYNC_FIRST:  cfg_reg.sync_first  <= pwdata[3:0];
                REG_SYNC_SECOND: cfg_reg.sync_second <= pwdata[3:0];
                REG_QUALITY:     cfg_reg.quality     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SYNC_FIRST:  prdata = {28'd0, cfg_reg.sync_first};
            REG_SYNC_SECOND: prdata = {28'd0, cfg_reg.sync_second};
            REG_QUALITY:     prdata = {24'd0, cfg_reg.quality};
            default:         prdata = '0;
        endcase
    end

    lcd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .evt       (evt),
        .cmd       (cmd)
    );

    lcd_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .evt          (evt),
        .in_byte      (s_tdata),
        .in_restart   (s_tuser[0]),
        .out_status   (m_tuser),
        .out_angle    (angle),
        .out_distance (distance),
        .out_quality  (quality),
        .out_revs     (revs),
        .out_last     (m_tlast)
    );

    assign m_tdata = {1'b0, revs, quality, distance, angle};

endmodule
